// ===== hdl/sc2a_pkg.sv =====
`timescale 1ns / 1ps

package sc2a_pkg;

	localparam logic [7:0] SC_LSHIFT_MAKE  = 8'h2A;
	localparam logic [7:0] SC_RSHIFT_MAKE  = 8'h36;
	localparam logic [7:0] SC_LSHIFT_BREAK = 8'hAA;
	localparam logic [7:0] SC_RSHIFT_BREAK = 8'hB6;
	localparam logic [7:0] SC_CTRL_MAKE    = 8'h1D;
	localparam logic [7:0] SC_CTRL_BREAK   = 8'h9D;
	localparam logic [7:0] SC_KEY_C        = 8'h2E;
	localparam logic [7:0] SC_BACKSPACE    = 8'h0E;
	localparam logic [7:0] SC_ENTER        = 8'h1C;
	localparam logic [7:0] XLAT_SIZE       = 8'd58;
	localparam logic [7:0] COUNT_MAX       = 8'd255;

	localparam int unsigned CODE_W  = 8;
	localparam int unsigned KIND_W  = 3;
	localparam int unsigned CHAR_W  = 7;
	localparam int unsigned COUNT_W = 8;
	localparam int unsigned XLAT_IDX_W = 6;

	typedef logic [CODE_W-1:0]  code_t;
	typedef logic [KIND_W-1:0]  kind_t;
	typedef logic [CHAR_W-1:0]  char_t;
	typedef logic [COUNT_W-1:0] count_t;

	localparam kind_t EV_NONE   = 3'd0;
	localparam kind_t EV_ECHO   = 3'd1;
	localparam kind_t EV_ERASE  = 3'd2;
	localparam kind_t EV_SUBMIT = 3'd3;
	localparam kind_t EV_CANCEL = 3'd4;

	// us layout, padded to 64 entries with zeros
	localparam char_t PLAIN_MAP [0:63] = '{
		7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
		7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
		7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
		7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73,
		7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
		7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
		7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
		7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
	};

	localparam char_t UPPER_MAP [0:63] = '{
		7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
		7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
		7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
		7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00, 7'h41, 7'h53,
		7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
		7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
		7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A,
		7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
	};

endpackage

// ===== hdl/scancode_to_ascii_line_editor.sv =====
`timescale 1ns / 1ps

// Set 1 scan code front end for a line editor. Each request carries one raw
// scan code byte; each produces exactly one result with an event kind (none,
// echo, erase, submit, cancel), the echoed ASCII character and the line length
// after the step. Shift and control make/break codes are tracked internally.
// The block takes one request per cycle while the result side is free: a
// request is decoded in the input register, where the modifier/count update
// also happens, and then sits in the result register until taken; both
// registers advance together whenever the result side is free.
module scancode_to_ascii_line_editor #(
	parameter int LINE_LIMIT = 254
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  sc2a_pkg::code_t     scan_code,
	output logic                out_valid,
	input  logic                out_ready,
	output sc2a_pkg::kind_t     event_kind,
	output sc2a_pkg::char_t     character,
	output sc2a_pkg::count_t    line_length
);
	import sc2a_pkg::*;

	logic   valid_s1;
	code_t  code_s1;
	logic   valid_s2;
	kind_t  kind_s2;
	char_t  char_s2;
	count_t length_s2;

	logic   shift_q;
	logic   ctrl_q;
	count_t count_q;

	logic   adv;
	logic   take_s1;

	kind_t  kind_d;
	char_t  char_d;
	count_t count_d;
	logic   shift_d;
	logic   ctrl_d;
	char_t  xlat;
	logic   has_room;

	assign adv      = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || adv;
	assign take_s1  = valid_s1 && adv;

	assign xlat = shift_q ? UPPER_MAP[code_s1[XLAT_IDX_W-1:0]]
	                      : PLAIN_MAP[code_s1[XLAT_IDX_W-1:0]];
	assign has_room = (32'(count_q) < LINE_LIMIT) && (count_q < COUNT_MAX);

	always_comb begin
		kind_d  = EV_NONE;
		char_d  = '0;
		count_d = count_q;
		shift_d = shift_q;
		ctrl_d  = ctrl_q;
		if (code_s1 == SC_LSHIFT_MAKE || code_s1 == SC_RSHIFT_MAKE) begin
			shift_d = 1'b1;
		end else if (code_s1 == SC_LSHIFT_BREAK || code_s1 == SC_RSHIFT_BREAK) begin
			shift_d = 1'b0;
		end else if (code_s1 == SC_CTRL_MAKE) begin
			ctrl_d = 1'b1;
		end else if (code_s1 == SC_CTRL_BREAK) begin
			ctrl_d = 1'b0;
		end else if (code_s1[CODE_W-1]) begin
			kind_d = EV_NONE;
		end else if (ctrl_q && code_s1 == SC_KEY_C) begin
			kind_d  = EV_CANCEL;
			count_d = '0;
		end else if (code_s1 == SC_BACKSPACE) begin
			if (count_q != '0) begin
				kind_d  = EV_ERASE;
				count_d = count_q - 8'd1;
			end
		end else if (code_s1 == SC_ENTER) begin
			kind_d  = EV_SUBMIT;
			count_d = '0;
		end else if (code_s1 < XLAT_SIZE && xlat != '0 && has_room) begin
			kind_d  = EV_ECHO;
			char_d  = xlat;
			count_d = count_q + 8'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			shift_q  <= 1'b0;
			ctrl_q   <= 1'b0;
			count_q  <= '0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (adv) begin
				valid_s2 <= valid_s1;
			end
			if (take_s1) begin
				shift_q <= shift_d;
				ctrl_q  <= ctrl_d;
				count_q <= count_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			code_s1 <= scan_code;
		end
		if (take_s1) begin
			kind_s2   <= kind_d;
			char_s2   <= char_d;
			length_s2 <= count_d;
		end
	end

	assign out_valid   = valid_s2;
	assign event_kind  = kind_s2;
	assign character   = char_s2;
	assign line_length = length_s2;

	// line length stays within the limit or the saturation point
	a_length_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (32'(line_length) <= LINE_LIMIT || line_length == COUNT_MAX))
		else $error("line length above limit");

	// character only carried by echo events
	a_char_only_echo: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && event_kind != EV_ECHO) |-> character == '0)
		else $error("character set on non-echo event");

	// submit and cancel empty the line
	a_clear_on_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (event_kind == EV_SUBMIT || event_kind == EV_CANCEL))
		|-> line_length == '0)
		else $error("line not cleared on submit or cancel");

	// editor state only moves when a request leaves the input stage
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!take_s1 |=> ($stable(count_q) && $stable(shift_q) && $stable(ctrl_q)))
		else $error("editor state changed without a request");

	// reported length tracks the internal count
	a_length_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		take_s1 |=> (line_length == count_q))
		else $error("reported length differs from count");

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import sc2a_pkg::*;

	localparam int EDIT_LIMIT = 254;
	localparam int LONG_HOLD  = 300;
	localparam int IDLE_LIMIT = 3000;

	typedef struct packed {
		kind_t  kind;
		char_t  ch;
		count_t len;
	} editor_event_t;

	// us layout, scan codes 0 to 57
	localparam char_t LOWER_KEYS [0:57] = '{
		7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
		7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
		7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
		7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73,
		7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
		7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
		7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
		7'h00, 7'h20
	};

	localparam char_t UPPER_KEYS [0:57] = '{
		7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
		7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
		7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
		7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00, 7'h41, 7'h53,
		7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
		7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
		7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A,
		7'h00, 7'h20
	};

	logic   clk = 1'b0;
	logic   arst_n = 1'b0;
	logic   in_valid = 1'b0;
	logic   in_ready;
	code_t  scan_code = '0;
	logic   out_valid;
	logic   out_ready = 1'b0;
	kind_t  event_kind;
	char_t  character;
	count_t line_length;

	code_t         key_queue [$];
	editor_event_t expected_events [$];

	logic   shift_down = 1'b0;
	logic   ctrl_down = 1'b0;
	count_t typed_count = '0;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	logic send_hold = 1'b0;
	int hold_req = 0;
	int hold_ack = 0;
	int hold_left = 0;
	int err_count = 0;
	int result_count = 0;
	int quiet_cycles = 0;

	scancode_to_ascii_line_editor #(
		.LINE_LIMIT(EDIT_LIMIT)
	) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.scan_code  (scan_code),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.event_kind (event_kind),
		.character  (character),
		.line_length(line_length)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic editor_event_t predict_key_event(code_t code);
		editor_event_t ev;
		char_t c;
		ev.kind = EV_NONE;
		ev.ch = '0;
		if (code == SC_LSHIFT_MAKE || code == SC_RSHIFT_MAKE) begin
			shift_down = 1'b1;
		end else if (code == SC_LSHIFT_BREAK || code == SC_RSHIFT_BREAK) begin
			shift_down = 1'b0;
		end else if (code == SC_CTRL_MAKE) begin
			ctrl_down = 1'b1;
		end else if (code == SC_CTRL_BREAK) begin
			ctrl_down = 1'b0;
		end else if (code[7]) begin
			// other releases change nothing
		end else if (ctrl_down && code == SC_KEY_C) begin
			typed_count = '0;
			ev.kind = EV_CANCEL;
		end else if (code == SC_BACKSPACE) begin
			if (typed_count != '0) begin
				typed_count = typed_count - 8'd1;
				ev.kind = EV_ERASE;
			end
		end else if (code == SC_ENTER) begin
			typed_count = '0;
			ev.kind = EV_SUBMIT;
		end else if (code < XLAT_SIZE) begin
			c = shift_down ? UPPER_KEYS[code[5:0]] : LOWER_KEYS[code[5:0]];
			// count saturates at the line limit and never wraps
			if (c != '0 && int'(typed_count) < EDIT_LIMIT && typed_count != 8'hFF) begin
				typed_count = typed_count + 8'd1;
				ev.kind = EV_ECHO;
				ev.ch = c;
			end
		end
		ev.len = typed_count;
		return ev;
	endfunction

	task automatic report_mismatch(string field, int got, int want);
		$display("mismatch in %s of result %0d: got %0d, want %0d",
			field, result_count, got, want);
		err_count++;
	endtask

	task automatic queue_keystrokes(int n);
		for (int i = 0; i < n; i++) begin
			int pick;
			code_t k;
			pick = $urandom_range(99);
			if (pick < 55) begin
				k = code_t'($urandom_range(57, 1));
				key_queue.push_back(k);
				if ($urandom_range(3) == 0)
					key_queue.push_back(k | 8'h80);
			end else if (pick < 62) begin
				key_queue.push_back($urandom_range(1) ? SC_LSHIFT_MAKE : SC_RSHIFT_MAKE);
			end else if (pick < 69) begin
				key_queue.push_back($urandom_range(1) ? SC_LSHIFT_BREAK : SC_RSHIFT_BREAK);
			end else if (pick < 73) begin
				key_queue.push_back(SC_CTRL_MAKE);
			end else if (pick < 77) begin
				key_queue.push_back(SC_CTRL_BREAK);
			end else if (pick < 80) begin
				key_queue.push_back(SC_KEY_C);
			end else if (pick < 87) begin
				key_queue.push_back(SC_BACKSPACE);
			end else if (pick < 90) begin
				key_queue.push_back(SC_ENTER);
			end else begin
				key_queue.push_back(code_t'($urandom_range(255)));
			end
		end
	endtask

	// letters only, so the line grows without being cleared
	task automatic queue_long_line(int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(1))
				key_queue.push_back(code_t'($urandom_range(8'h19, 8'h10)));
			else
				key_queue.push_back(code_t'($urandom_range(8'h26, 8'h1E)));
		end
	endtask

	task automatic drain_phase();
		while (key_queue.size() != 0 || in_valid)
			@(negedge clk);
		send_hold = 1'b1;
		while (expected_events.size() != 0)
			@(negedge clk);
		send_hold = 1'b0;
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		key_queue = '{8'h00, 8'hFF, 8'h80, 8'h01, 8'h0F, 8'h10, SC_LSHIFT_MAKE, 8'h10,
			8'h02, 8'h2B, SC_LSHIFT_BREAK, SC_RSHIFT_MAKE, 8'h0B, SC_RSHIFT_BREAK,
			SC_CTRL_MAKE, 8'h10, SC_KEY_C, SC_CTRL_BREAK, SC_KEY_C, SC_BACKSPACE,
			SC_BACKSPACE, SC_BACKSPACE, SC_ENTER, SC_ENTER, 8'h39, 8'h3A, 8'h7F,
			8'h90};
		queue_long_line(275);
		key_queue.push_back(SC_BACKSPACE);
		queue_long_line(2);
		key_queue.push_back(SC_ENTER);
		queue_keystrokes(200);
		drain_phase();

		send_idle_pct = 88;
		queue_keystrokes(200);
		drain_phase();

		send_idle_pct = 0;
		recv_stall_pct = 88;
		queue_keystrokes(200);
		drain_phase();

		// long receiver hold-off while requests keep coming
		send_idle_pct = 19;
		recv_stall_pct = 19;
		hold_req++;
		queue_keystrokes(200);
		drain_phase();

		repeat (8) @(posedge clk);
		if (err_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	always @(posedge clk) begin
		logic nv;
		code_t nc;
		nv = in_valid;
		nc = scan_code;
		if (in_valid && in_ready)
			nv = 1'b0;
		if (!nv && arst_n && !send_hold && key_queue.size() != 0
				&& $urandom_range(99) >= send_idle_pct) begin
			nv = 1'b1;
			nc = key_queue.pop_front();
		end
		in_valid <= nv;
		scan_code <= nc;
	end

	always @(posedge clk) begin
		editor_event_t want;
		if (out_valid && out_ready) begin
			if (expected_events.size() == 0) begin
				$display("unexpected result: kind %0d char %0d length %0d",
					event_kind, character, line_length);
				err_count++;
			end else begin
				want = expected_events.pop_front();
				if (event_kind !== want.kind)
					report_mismatch("event_kind", int'(event_kind), int'(want.kind));
				if (character !== want.ch)
					report_mismatch("character", int'(character), int'(want.ch));
				if (line_length !== want.len)
					report_mismatch("line_length", int'(line_length), int'(want.len));
			end
			result_count++;
		end
		if (in_valid && in_ready)
			expected_events.push_back(predict_key_event(scan_code));
		if (hold_ack != hold_req) begin
			hold_ack++;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

endmodule
